// ===== rtl/core/lcc_pkg.sv =====
package lcc_pkg;

  localparam int LCC_MAX_VERTICES = 1024;
  localparam int LCC_MAX_EDGES    = 4096;

  localparam int LCC_VERT_W  = 10;
  localparam int LCC_COUNT_W = 11;
  localparam int LCC_EDGE_W  = 2 * LCC_VERT_W;

  localparam logic FUNC_ADD     = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP,
    ST_POP_WAIT,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_VIS_CHK
  } lcc_state_t;

endpackage

// ===== rtl/core/lcc_ifs.sv =====
interface lcc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [lcc_pkg::LCC_VERT_W-1:0] end_a;
  logic [lcc_pkg::LCC_VERT_W-1:0] end_b;
  modport source (output valid, func, end_a, end_b, input ready);
  modport sink   (input valid, func, end_a, end_b, output ready);
endinterface

interface lcc_out_if;
  logic                           valid;
  logic                           ready;
  logic [lcc_pkg::LCC_COUNT_W-1:0] largest_size;
  logic                           edge_overflow;
  modport source (output valid, largest_size, edge_overflow, input ready);
  modport sink   (input valid, largest_size, edge_overflow, output ready);
endinterface

interface lcc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lcc_pkg::LCC_COUNT_W-1:0] vertex_count;
  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

// ===== rtl/core/lcc_ram.sv =====
module lcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== rtl/core/largest_connected_component_unit.sv =====
// Largest connected component unit. Edges arrive one per transfer (func = add)
// and are written to the edge memory; an edge with an endpoint not below the
// vertex count, or one arriving with the store full, is dropped and sets the
// sticky edge_overflow flag. A compute transfer runs a depth-first walk over
// the stored graph using an explicit stack memory: each root gets a visited
// lookup, each popped vertex a scan of all stored edges through the single read
// port of the edge memory, and each matching edge a visited lookup of its other
// end. The result is then presented while the visited map is swept clear; the
// same sweep runs once after reset. No new input transfer is taken until the
// sweep ends and the result has been transferred.
module largest_connected_component_unit #(
  parameter int MAX_VERTICES = lcc_pkg::LCC_MAX_VERTICES,
  parameter int MAX_EDGES    = lcc_pkg::LCC_MAX_EDGES
) (
  input  logic      clk,
  input  logic      rst_n,
  lcc_in_if.sink    in_ch,
  lcc_out_if.source out_ch,
  lcc_cfg_if.sink   cfg_ch
);

  import lcc_pkg::*;

  localparam int VAW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW  = $clog2(MAX_EDGES + 1);
  localparam int SPW  = $clog2(MAX_VERTICES + 1);

  lcc_state_t state_r, state_nxt;

  logic [LCC_COUNT_W-1:0] vcount_r, vcount_nxt;
  logic [ETW-1:0]         edge_total_r, edge_total_nxt;
  logic                   overflow_r, overflow_nxt;
  logic [LCC_COUNT_W-1:0] best_r, best_nxt;
  logic [LCC_COUNT_W-1:0] cur_r, cur_nxt;
  logic [LCC_COUNT_W-1:0] root_r, root_nxt;
  logic [SPW-1:0]         sp_r, sp_nxt;
  logic [ETW-1:0]         eidx_r, eidx_nxt;
  logic [VAW-1:0]         v_r, v_nxt;
  logic [VAW-1:0]         w_r, w_nxt;
  logic [VAW-1:0]         clr_r, clr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [LCC_COUNT_W-1:0] out_size_r, out_size_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  // memory ports
  logic                  edge_we;
  logic [EAW-1:0]        edge_waddr, edge_raddr;
  logic [LCC_EDGE_W-1:0] edge_wdata, edge_rdata;
  logic                  vis_we, vis_wdata, vis_rdata;
  logic [VAW-1:0]        vis_waddr, vis_raddr;
  logic                  stk_we;
  logic [VAW-1:0]        stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  // derived values
  logic [LCC_COUNT_W-1:0] n_eff;
  logic                   in_xfer, out_xfer, cfg_xfer;
  logic [LCC_VERT_W-1:0]  ea, eb;
  logic                   e_in_range, hit_a, hit_b, edge_hit;
  logic [VAW-1:0]         e_other;
  logic                   in_a_ok, in_b_ok, store_full, stack_room;

  assign n_eff = (32'(vcount_r) > MAX_VERTICES) ? LCC_COUNT_W'(MAX_VERTICES) : vcount_r;

  assign in_ch.ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign cfg_xfer = cfg_ch.valid && cfg_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.largest_size  = out_size_r;
  assign out_ch.edge_overflow = out_ovf_r;

  assign in_a_ok    = {1'b0, in_ch.end_a} < n_eff;
  assign in_b_ok    = {1'b0, in_ch.end_b} < n_eff;
  assign store_full = (edge_total_r == ETW'(MAX_EDGES));
  assign stack_room = (sp_r != SPW'(MAX_VERTICES));

  // incident-edge check on the edge just read
  assign ea         = edge_rdata[LCC_EDGE_W-1:LCC_VERT_W];
  assign eb         = edge_rdata[LCC_VERT_W-1:0];
  assign e_in_range = ({1'b0, ea} < n_eff) && ({1'b0, eb} < n_eff);
  assign hit_a      = (32'(ea) == 32'(v_r));
  assign hit_b      = (32'(eb) == 32'(v_r));
  assign edge_hit   = e_in_range && (hit_a || hit_b);
  assign e_other    = hit_a ? VAW'(eb) : VAW'(ea);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == VAW'(MAX_VERTICES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer && in_ch.func == FUNC_COMPUTE) state_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        state_nxt = (root_r == n_eff) ? ST_CLEAR : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        state_nxt = vis_rdata ? ST_SCAN_RD : ST_POP;
      end
      ST_POP: begin
        state_nxt = (sp_r == '0) ? ST_SCAN_RD : ST_POP_WAIT;
      end
      ST_POP_WAIT: state_nxt = ST_EDGE_RD;
      ST_EDGE_RD: begin
        state_nxt = (eidx_r == edge_total_r) ? ST_POP : ST_EDGE_CHK;
      end
      ST_EDGE_CHK: begin
        state_nxt = edge_hit ? ST_VIS_CHK : ST_EDGE_RD;
      end
      ST_VIS_CHK: state_nxt = ST_EDGE_RD;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  // memory controls and register updates
  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = EAW'(edge_total_r);
    edge_wdata = {in_ch.end_a, in_ch.end_b};
    edge_raddr = EAW'(eidx_r);
    vis_we     = 1'b0;
    vis_waddr  = clr_r;
    vis_wdata  = 1'b0;
    vis_raddr  = VAW'(root_r);
    stk_we     = 1'b0;
    stk_waddr  = VAW'(sp_r);
    stk_wdata  = w_r;
    stk_raddr  = VAW'(sp_r - SPW'(1));

    vcount_nxt     = cfg_xfer ? cfg_ch.vertex_count : vcount_r;
    edge_total_nxt = edge_total_r;
    overflow_nxt   = overflow_r;
    best_nxt       = best_r;
    cur_nxt        = cur_r;
    root_nxt       = root_r;
    sp_nxt         = sp_r;
    eidx_nxt       = eidx_r;
    v_nxt          = v_r;
    w_nxt          = w_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = out_valid_r && !out_xfer;
    out_size_nxt   = out_size_r;
    out_ovf_nxt    = out_ovf_r;

    case (state_r)
      ST_CLEAR: begin
        vis_we  = 1'b1;
        clr_nxt = clr_r + VAW'(1);
      end
      ST_IDLE: begin
        if (in_xfer && in_ch.func == FUNC_ADD) begin
          if (in_a_ok && in_b_ok && !store_full) begin
            edge_we        = 1'b1;
            edge_total_nxt = edge_total_r + ETW'(1);
          end else begin
            overflow_nxt = 1'b1;
          end
        end else if (in_xfer) begin
          best_nxt = '0;
          root_nxt = '0;
        end
      end
      ST_SCAN_RD: begin
        if (root_r == n_eff) begin
          // walk done: post the result and reset the case
          out_valid_nxt  = 1'b1;
          out_size_nxt   = best_r;
          out_ovf_nxt    = overflow_r;
          edge_total_nxt = '0;
          overflow_nxt   = 1'b0;
          clr_nxt        = '0;
        end
      end
      ST_SCAN_CHK: begin
        if (vis_rdata) begin
          root_nxt = root_r + LCC_COUNT_W'(1);
        end else begin
          vis_we    = 1'b1;
          vis_waddr = VAW'(root_r);
          vis_wdata = 1'b1;
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = VAW'(root_r);
          sp_nxt    = SPW'(1);
          cur_nxt   = LCC_COUNT_W'(1);
        end
      end
      ST_POP: begin
        if (sp_r == '0) begin
          if (cur_r > best_r) best_nxt = cur_r;
          root_nxt = root_r + LCC_COUNT_W'(1);
        end else begin
          sp_nxt = sp_r - SPW'(1);
        end
      end
      ST_POP_WAIT: begin
        v_nxt    = stk_rdata;
        eidx_nxt = '0;
      end
      ST_EDGE_CHK: begin
        vis_raddr = e_other;
        w_nxt     = e_other;
        if (!edge_hit) eidx_nxt = eidx_r + ETW'(1);
      end
      ST_VIS_CHK: begin
        if (!vis_rdata && stack_room) begin
          vis_we    = 1'b1;
          vis_waddr = w_r;
          vis_wdata = 1'b1;
          stk_we    = 1'b1;
          sp_nxt    = sp_r + SPW'(1);
          cur_nxt   = cur_r + LCC_COUNT_W'(1);
        end
        eidx_nxt = eidx_r + ETW'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      vcount_r     <= LCC_COUNT_W'(1);
      edge_total_r <= '0;
      overflow_r   <= 1'b0;
      best_r       <= '0;
      cur_r        <= '0;
      root_r       <= '0;
      sp_r         <= '0;
      eidx_r       <= '0;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vcount_r     <= vcount_nxt;
      edge_total_r <= edge_total_nxt;
      overflow_r   <= overflow_nxt;
      best_r       <= best_nxt;
      cur_r        <= cur_nxt;
      root_r       <= root_nxt;
      sp_r         <= sp_nxt;
      eidx_r       <= eidx_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    w_r        <= w_nxt;
    out_size_r <= out_size_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  lcc_ram #(.WIDTH(LCC_EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk     (clk),
    .we      (edge_we),
    .waddr   (edge_waddr),
    .wdata   (edge_wdata),
    .raddr   (edge_raddr),
    .rdata_r (edge_rdata)
  );

  lcc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_vis_ram (
    .clk     (clk),
    .we      (vis_we),
    .waddr   (vis_waddr),
    .wdata   (vis_wdata),
    .raddr   (vis_raddr),
    .rdata_r (vis_rdata)
  );

  lcc_ram #(.WIDTH(VAW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk     (clk),
    .we      (stk_we),
    .waddr   (stk_waddr),
    .wdata   (stk_wdata),
    .raddr   (stk_raddr),
    .rdata_r (stk_rdata)
  );

  // edge count never passes the store depth
  a_edge_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(edge_total_r) <= MAX_EDGES)
    else $error("edge count beyond store depth");

  // stack pointer never passes the stack depth
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= MAX_VERTICES)
    else $error("walk stack overrun");

  // a posted result leaves the edge store and overflow flag cleared
  a_case_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (edge_total_r == '0) && !overflow_r)
    else $error("case state not cleared with result");

  // the component being walked never outgrows the vertex count
  a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VIS_CHK) |-> (cur_r <= n_eff))
    else $error("component size beyond vertex count");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import lcc_pkg::*;

  typedef struct packed {
    logic [LCC_COUNT_W-1:0] size;
    logic                   ovf;
  } lcc_result_t;

  typedef enum logic [1:0] {ROW_ADD, ROW_COMPUTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [LCC_VERT_W-1:0]  a;
    logic [LCC_VERT_W-1:0]  b;
    logic [LCC_COUNT_W-1:0] cfg_val;
    bit                     typed;
    lcc_result_t            res;
  } stim_row_t;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 20;
  localparam int SWEEP_CYCLES   = LCC_MAX_VERTICES + 64;
  localparam int PRESSURE_ADDS  = 4;

  logic clk;
  logic rst_n;

  lcc_in_if  in_if();
  lcc_out_if out_if();
  lcc_cfg_if cfg_if();

  largest_connected_component_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // shadow copy of the block state
  logic [LCC_COUNT_W-1:0] vert_cfg;
  logic [LCC_VERT_W-1:0]  store_a[$];
  logic [LCC_VERT_W-1:0]  store_b[$];
  bit                     drop_seen;

  lcc_result_t pending_sizes[$];
  int          fail_count;
  bit          idle_on;
  bit          hold_req;
  int          quiet_cycles;

  always #5 clk = ~clk;

  function automatic int live_count();
    return (vert_cfg > LCC_MAX_VERTICES) ? LCC_MAX_VERTICES : int'(vert_cfg);
  endfunction

  // depth-first walk of every component, returns the largest size
  function automatic lcc_result_t component_peak();
    bit          seen[LCC_MAX_VERTICES];
    int          stk[$];
    int          n, best, cur, v, w, e, ea, eb;
    lcc_result_t r;
    n = live_count();
    best = 0;
    foreach (seen[i]) seen[i] = 0;
    for (int root = 0; root < n; root++) begin
      if (!seen[root]) begin
        seen[root] = 1;
        stk.push_back(root);
        cur = 1;
        while (stk.size() > 0) begin
          v = stk.pop_back();
          for (e = 0; e < store_a.size(); e++) begin
            ea = store_a[e];
            eb = store_b[e];
            if (ea >= n || eb >= n) continue;
            if (ea == v) w = eb;
            else if (eb == v) w = ea;
            else continue;
            if (!seen[w] && stk.size() < LCC_MAX_VERTICES) begin
              seen[w] = 1;
              stk.push_back(w);
              cur++;
            end
          end
        end
        if (cur > best) best = cur;
      end
    end
    r.size = best[LCC_COUNT_W-1:0];
    r.ovf  = drop_seen;
    return r;
  endfunction

  // update the shadow state for one accepted item, queue any result
  task automatic absorb_item(logic f, logic [LCC_VERT_W-1:0] a, logic [LCC_VERT_W-1:0] b,
                             bit typed, lcc_result_t typed_res);
    int n;
    n = live_count();
    if (f == FUNC_ADD) begin
      if (a >= n || b >= n || store_a.size() >= LCC_MAX_EDGES) drop_seen = 1;
      else begin
        store_a.push_back(a);
        store_b.push_back(b);
      end
    end else begin
      pending_sizes.push_back(typed ? typed_res : component_peak());
      store_a.delete();
      store_b.delete();
      drop_seen = 0;
    end
  endtask

  // one input transfer; valid stays high into the next item unless idling
  task automatic send_item(logic f, logic [LCC_VERT_W-1:0] a, logic [LCC_VERT_W-1:0] b,
                           bit typed = 0, lcc_result_t typed_res = '0);
    while (idle_on && $urandom_range(99) < 32) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.func  <= f;
    in_if.end_a <= a;
    in_if.end_b <= b;
    do @(posedge clk); while (!in_if.ready);
    absorb_item(f, a, b, typed, typed_res);
    @(negedge clk);
  endtask

  // register write only once the block has gone quiet
  task automatic write_vertex_count(logic [LCC_COUNT_W-1:0] v);
    in_if.valid <= 1'b0;
    while (pending_sizes.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.vertex_count <= v;
    do @(posedge clk); while (!cfg_if.ready);
    vert_cfg = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // result side: random ready, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_req) begin
      out_if.ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 0;
    end else begin
      out_if.ready <= !(idle_on && $urandom_range(99) < 32);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    lcc_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_sizes.size() == 0) begin
        $display("%0t: unexpected result size=%0d ovf=%0d", $time,
                 out_if.largest_size, out_if.edge_overflow);
        fail_count++;
      end else begin
        want = pending_sizes.pop_front();
        if (out_if.largest_size !== want.size) begin
          $display("%0t: largest_size expected %0d got %0d", $time, want.size,
                   out_if.largest_size);
          fail_count++;
        end
        if (out_if.edge_overflow !== want.ovf) begin
          $display("%0t: edge_overflow expected %0d got %0d", $time, want.ovf,
                   out_if.edge_overflow);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  stim_row_t rows[$];

  task automatic add_row(row_kind_t k, int a = 0, int b = 0, int cv = 0,
                         bit typed = 0, int sz = 0, bit ovf = 0);
    stim_row_t r;
    r.kind = k;
    r.a = LCC_VERT_W'(a);
    r.b = LCC_VERT_W'(b);
    r.cfg_val = LCC_COUNT_W'(cv);
    r.typed = typed;
    r.res.size = LCC_COUNT_W'(sz);
    r.res.ovf = ovf;
    rows.push_back(r);
  endtask

  initial begin
    int          items, n, edges, x, y;
    bit          held;
    lcc_result_t full_res;
    clk = 0;
    rst_n = 0;
    in_if.valid = 0;
    in_if.func = FUNC_ADD;
    in_if.end_a = '0;
    in_if.end_b = '0;
    out_if.ready = 0;
    cfg_if.valid = 0;
    cfg_if.vertex_count = '0;
    vert_cfg = 1;
    drop_seen = 0;
    fail_count = 0;
    idle_on = 1;
    hold_req = 0;
    quiet_cycles = 0;
    repeat (2) @(negedge clk);
    rst_n = 1;

    // directed table
    add_row(ROW_COMPUTE, 0, 0, 0, 1, 1, 0);            // single vertex after reset
    add_row(ROW_ADD, 0, 0);
    add_row(ROW_ADD, 1, 0);                             // endpoint out of range
    add_row(ROW_COMPUTE, 0, 0, 0, 1, 1, 1);
    add_row(ROW_CFG, 0, 0, 0);                          // empty graph
    add_row(ROW_ADD, 0, 0);
    add_row(ROW_COMPUTE, 0, 0, 0, 1, 0, 1);
    add_row(ROW_CFG, 0, 0, 2047);                       // too large, acts as maximum
    add_row(ROW_ADD, 1023, 0);
    add_row(ROW_ADD, 1023, 1023);
    add_row(ROW_ADD, 512, 1023);
    add_row(ROW_COMPUTE, 0, 0, 0, 1, 3, 0);
    add_row(ROW_CFG, 0, 0, 8);
    add_row(ROW_ADD, 1, 2);
    add_row(ROW_ADD, 2, 3);
    add_row(ROW_ADD, 3, 3);                             // self loop
    add_row(ROW_ADD, 2, 1);                             // repeated edge
    add_row(ROW_ADD, 5, 6);
    add_row(ROW_CFG, 0, 0, 3);                          // lowered after adds
    add_row(ROW_COMPUTE);
    add_row(ROW_CFG, 0, 0, 1024);
    add_row(ROW_ADD, 341, 682);
    add_row(ROW_ADD, 682, 1023);
    add_row(ROW_COMPUTE);
    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_CFG: write_vertex_count(rows[i].cfg_val);
        ROW_ADD: send_item(FUNC_ADD, rows[i].a, rows[i].b);
        default: send_item(FUNC_COMPUTE, rows[i].a, rows[i].b, rows[i].typed, rows[i].res);
      endcase
    end

    // fill the edge store, then one more edge that must be dropped
    write_vertex_count(LCC_COUNT_W'(1));
    for (int i = 0; i <= LCC_MAX_EDGES; i++) send_item(FUNC_ADD, '0, '0);
    full_res.size = LCC_COUNT_W'(1);
    full_res.ovf = 1;
    send_item(FUNC_COMPUTE, LCC_VERT_W'($urandom), LCC_VERT_W'($urandom), 1, full_res);

    // random graphs, mostly small; first stretch without idling
    items = 0;
    idle_on = 0;
    while (items < 800) begin
      if (items > 150) idle_on = 1;
      x = $urandom_range(99);
      if (x < 90) n = $urandom_range(1, 40);
      else if (x < 95) n = $urandom_range(41, 1024);
      else if (x < 97) n = 0;
      else n = $urandom_range(1025, 2047);
      write_vertex_count(LCC_COUNT_W'(n));
      edges = (n > 40) ? $urandom_range(0, 6) : $urandom_range(0, 20);
      for (int i = 0; i < edges; i++) begin
        if (live_count() > 0 && $urandom_range(99) < 85) begin
          x = $urandom_range(live_count() - 1);
          y = $urandom_range(live_count() - 1);
        end else begin
          x = $urandom_range(1023);
          y = $urandom_range(1023);
        end
        send_item(FUNC_ADD, LCC_VERT_W'(x), LCC_VERT_W'(y));
        items++;
      end
      if (n > 1 && n <= 40 && $urandom_range(99) < 10)
        write_vertex_count(LCC_COUNT_W'($urandom_range(0, n - 1)));
      // long receiver hold-offs while the next case keeps offering items
      held = 0;
      if (items > 400 && items < 430) begin
        hold_req = 1;
        held = 1;
      end
      send_item(FUNC_COMPUTE, LCC_VERT_W'($urandom), LCC_VERT_W'($urandom));
      items++;
      if (held) begin
        for (int i = 0; i < PRESSURE_ADDS; i++) begin
          send_item(FUNC_ADD, '0, '0);
          items++;
        end
      end
    end
    in_if.valid <= 1'b0;

    while (pending_sizes.size() > 0) @(negedge clk);
    repeat (SWEEP_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lcc_pkg.sv
rtl/core/lcc_ifs.sv
rtl/core/lcc_ram.sv
rtl/core/largest_connected_component_unit.sv
verif/tb.sv
